// ===== rtl/fpde_pkg.sv =====
// ----------------------------------------------------------------------------
// fpde_pkg
// Shared types, register indexes and the control program of the
// difference equation core.
// ----------------------------------------------------------------------------
package fpde_pkg;

  localparam int TAPS_DEFAULT      = 3;
  localparam int FRAC_BITS_DEFAULT = 16;

  localparam int SAMPLE_W = 12;
  localparam int X_W      = 13;
  localparam int COEF_W   = 32;
  localparam int Y_W      = 32;
  localparam int ACC_W    = 64;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int STEP_W   = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B0  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B1  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B2  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A1  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A2  = 3'd5;

  localparam logic signed [X_W-1:0] OPEN_LOOP = -13'sd1;

  typedef enum logic [2:0] {
    OPND_X0   = 3'd0,
    OPND_X1   = 3'd1,
    OPND_Y1   = 3'd2,
    OPND_X2   = 3'd3,
    OPND_Y2   = 3'd4,
    OPND_NONE = 3'd5
  } opnd_sel_t;

  typedef enum logic [1:0] {
    ACC_NONE = 2'd0,
    ACC_LOAD = 2'd1,
    ACC_ADD  = 2'd2,
    ACC_SUB  = 2'd3
  } acc_op_t;

  typedef struct packed {
    opnd_sel_t          opnd;      // multiplier operand for this step
    acc_op_t            op;        // how the product joins the accumulator
    logic               skip_lag2; // jump when the second lag is absent
    logic [STEP_W-1:0]  jump_to;
    logic               last;      // result step
  } ctrl_word_t;

  localparam logic [STEP_W-1:0] STEP_DRAIN = 3'd5;

  function automatic ctrl_word_t ucode(input logic [STEP_W-1:0] step);
    ctrl_word_t cw;
    cw = '{opnd: OPND_NONE, op: ACC_NONE, skip_lag2: 1'b0, jump_to: '0, last: 1'b0};
    case (step)
      3'd0: begin cw.opnd = OPND_X0; cw.op = ACC_LOAD; end
      3'd1: begin cw.opnd = OPND_X1; cw.op = ACC_ADD; end
      3'd2: begin
        cw.opnd = OPND_Y1; cw.op = ACC_SUB;
        cw.skip_lag2 = 1'b1; cw.jump_to = STEP_DRAIN;
      end
      3'd3: begin cw.opnd = OPND_X2; cw.op = ACC_ADD; end
      3'd4: begin cw.opnd = OPND_Y2; cw.op = ACC_SUB; end
      3'd5: begin cw.opnd = OPND_NONE; cw.op = ACC_NONE; end
      3'd6: begin cw.last = 1'b1; end
      default: begin cw.last = 1'b1; end
    endcase
    return cw;
  endfunction

endpackage

// ===== rtl/fixed_point_difference_equation_core.sv =====
// ----------------------------------------------------------------------------
// fixed_point_difference_equation_core
// Second-order direct form I section with an optional setpoint error stage,
// run by a small control program over one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
// items are processed one at a time: a new item is accepted only once the current
// one has finished, with one multiply-accumulate pass per tap through the
//   single registered multiplier
// the next item is accepted while the previous result waits in the output register
// reset (rst, synchronous): setpoint = -1, coefficients and histories zero
module fixed_point_difference_equation_core #(
  parameter int TAPS      = fpde_pkg::TAPS_DEFAULT,
  parameter int FRAC_BITS = fpde_pkg::FRAC_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [11:0] sample, [15:12] zero
  input  logic        s_tuser,   // [0] clear_history
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] filter_out
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fpde_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fpde_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import fpde_pkg::*;

  localparam int  HIST_DEPTH = TAPS - 1;
  localparam bit  HAS_LAG2   = (TAPS > 2);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t state;
  logic [STEP_W-1:0] step;
  ctrl_word_t cw;

  logic signed [X_W-1:0]    setpoint;
  logic signed [COEF_W-1:0] coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;

  logic signed [X_W-1:0] x0;
  logic signed [X_W-1:0] x_hist [HIST_DEPTH];
  logic signed [Y_W-1:0] y_hist [HIST_DEPTH];
  logic signed [X_W-1:0] x2_val;
  logic signed [Y_W-1:0] y2_val;

  logic signed [SAMPLE_W+1:0] err;
  logic signed [X_W-1:0]      x_in;
  logic signed [COEF_W-1:0]   mul_a, mul_b;
  logic signed [ACC_W-1:0]    prod;
  acc_op_t                    prod_op;
  logic signed [ACC_W-1:0]    acc;
  logic signed [ACC_W-1:0]    acc_sh;
  logic signed [Y_W-1:0]      y_new;
  logic                       in_take;
  logic                       finish;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign in_take   = s_tvalid && s_tready;
  assign cw        = ucode(step);
  assign finish    = (state == ST_RUN) && cw.last && (!m_tvalid || m_tready);

  // lag-two taps exist only when the history is deep enough
  generate
    if (HAS_LAG2) begin : g_lag2
      assign x2_val = x_hist[1];
      assign y2_val = y_hist[1];
    end else begin : g_nolag2
      assign x2_val = '0;
      assign y2_val = '0;
    end
  endgenerate

  // filter input: sample in open loop, else saturated setpoint error
  always_comb begin
    err = {setpoint[X_W-1], setpoint} - $signed({2'b00, s_tdata[SAMPLE_W-1:0]});
    if (setpoint == OPEN_LOOP) begin
      x_in = $signed({1'b0, s_tdata[SAMPLE_W-1:0]});
    end else if (err < -14'sd4096) begin
      x_in = -13'sd4096;
    end else if (err > 14'sd4095) begin
      x_in = 13'sd4095;
    end else begin
      x_in = err[X_W-1:0];
    end
  end

  always_comb begin
    case (cw.opnd)
      OPND_X0: begin mul_a = COEF_W'(x0);        mul_b = coef_b0; end
      OPND_X1: begin mul_a = COEF_W'(x_hist[0]); mul_b = coef_b1; end
      OPND_Y1: begin mul_a = y_hist[0];          mul_b = coef_a1; end
      OPND_X2: begin mul_a = COEF_W'(x2_val);    mul_b = coef_b2; end
      OPND_Y2: begin mul_a = y2_val;             mul_b = coef_a2; end
      default: begin mul_a = '0;                 mul_b = '0;      end
    endcase
  end

  always_comb begin
    acc_sh = acc >>> FRAC_BITS;
    if (!(&acc_sh[ACC_W-1:Y_W-1]) && (|acc_sh[ACC_W-1:Y_W-1])) begin
      y_new = acc_sh[ACC_W-1] ? {1'b1, {(Y_W-1){1'b0}}} : {1'b0, {(Y_W-1){1'b1}}};
    end else begin
      y_new = acc_sh[Y_W-1:0];
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint <= OPEN_LOOP;
      coef_b0  <= '0;
      coef_b1  <= '0;
      coef_b2  <= '0;
      coef_a1  <= '0;
      coef_a2  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SETPOINT: setpoint <= cfg_data[X_W-1:0];
        REG_COEF_B0:  coef_b0  <= cfg_data;
        REG_COEF_B1:  coef_b1  <= cfg_data;
        REG_COEF_B2:  coef_b2  <= cfg_data;
        REG_COEF_A1:  coef_a1  <= cfg_data;
        REG_COEF_A2:  coef_a2  <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      step    <= '0;
      prod_op <= ACC_NONE;
    end else begin
      case (state)
        ST_IDLE: begin
          prod_op <= ACC_NONE;
          if (in_take) begin
            state <= ST_RUN;
            step  <= '0;
          end
        end
        ST_RUN: begin
          prod_op <= cw.op;
          if (cw.last) begin
            if (finish) begin
              state <= ST_IDLE;
            end
          end else if (cw.skip_lag2 && !HAS_LAG2) begin
            step <= cw.jump_to;
          end else begin
            step <= step + 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // multiplier then accumulator
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (prod_op)
      ACC_LOAD: acc <= prod;
      ACC_ADD:  acc <= acc + prod;
      ACC_SUB:  acc <= acc - prod;
      default:  acc <= acc;
    endcase
    if (in_take) begin
      x0 <= x_in;
    end
  end

  // histories shift by one lag per item
  always_ff @(posedge clk) begin
    if (rst || (in_take && s_tuser)) begin
      for (int i = 0; i < HIST_DEPTH; i++) begin
        x_hist[i] <= '0;
        y_hist[i] <= '0;
      end
    end else if (finish) begin
      x_hist[0] <= x0;
      y_hist[0] <= y_new;
      for (int i = 1; i < HIST_DEPTH; i++) begin
        x_hist[i] <= x_hist[i-1];
        y_hist[i] <= y_hist[i-1];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      m_tdata <= y_new;
    end
  end

endmodule
